// ===== src/jls_pkg.sv =====
// jls_pkg: shared types and constants of the Jacobi Laplace solver.
// No dependencies; used by the top level, jls_dp and jls_ctrl.
package jls_pkg;

  localparam int FUNC_W      = 2;
  localparam int IDX_W       = 12;
  localparam int IO_W        = 32;
  localparam int SWEEP_W     = 17;
  localparam int DIFF_W      = 31;
  localparam int PAIR_W      = 16;
  localparam int DIM_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int DIV_CNT_W   = $clog2(IDX_W);

  localparam logic [DIM_W-1:0]  COLS_RST  = 7'd64;
  localparam logic [DIM_W-1:0]  ROWS_RST  = 7'd64;
  localparam logic [DIFF_W-1:0] TOL_RST   = 31'd65;
  localparam logic [PAIR_W-1:0] PAIRS_RST = 16'hFFFF;
  localparam logic [DIFF_W-1:0] DIFF_SAT  = 31'h7FFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIRS = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SOLVE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;         // latch item, init divider, pair count, scan
    logic div_step;
    logic load_wr;
    logic sw_step;
    logic diff_step;
    logic scan_init;
    logic phase_flip;
    logic check;
    logic resp;        // load result payload
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  div_last;
    logic  sw_done;    // stencil of current cell complete this step
    logic  df_done;    // difference of current cell complete this step
    logic  last_cell;
    logic  phase;
    logic  finish;
  } sts_t;

endpackage

// ===== src/jls_if.sv =====
// jls_if: valid/ready channel interfaces for items in and results out.
// Depends on nothing.
interface jls_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [11:0]        cell_index;
  logic signed [31:0] cell_value;
  modport source (output valid, func, cell_index, cell_value, input ready);
  modport sink   (input valid, func, cell_index, cell_value, output ready);
endinterface

interface jls_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [16:0]        sweep_count;
  logic [30:0]        final_difference;
  logic               converged;
  modport source (output valid, read_value, sweep_count, final_difference, converged,
                  input ready);
  modport sink   (input valid, read_value, sweep_count, final_difference, converged,
                  output ready);
endinterface

// ===== src/jacobi_laplace_solver.sv =====
// jacobi_laplace_solver: top level of the Jacobi Laplace solver.
// Depends on jls_pkg, jls_if, jls_ctrl, jls_dp (and jls_ram below it).
//
// Five-point Jacobi relaxation on a grid of signed Q16.16 cells held in two
// on-chip memories (A and B, MAX_COLS*MAX_ROWS entries each, contents
// undefined until loaded, no clearing pass). Each item yields one result.
// A load item runs a restoring divide of the index by the column count to
// find row and column, then one write. A read addresses grid A and returns
// its registered data. A solve runs pairs of sweeps until the difference
// scan meets the tolerance or the pair limit is reached; each interior cell
// reads its four neighbors one at a time through the single read port of
// the source grid. A new item is accepted once the previous one has
// finished; a finished result may still sit in the output register then.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
module jacobi_laplace_solver #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jls_in_if.sink                          in_if,
  jls_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [jls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jls_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  jls_pkg::cmd_t cmd;
  jls_pkg::sts_t sts;
  jls_pkg::sts_t sts_ctrl;

  // in the idle state the controller decodes func from the port directly
  always_comb begin
    sts_ctrl      = sts;
    sts_ctrl.func = jls_pkg::func_t'(in_if.func);
  end

  jls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts_ctrl),
    .cmd       (cmd)
  );

  jls_dp #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_if.func),
    .in_idx    (in_if.cell_index),
    .in_val    (in_if.cell_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res_read  (out_if.read_value),
    .res_sweeps(out_if.sweep_count),
    .res_diff  (out_if.final_difference),
    .res_conv  (out_if.converged)
  );
endmodule

// ===== src/jls_ram.sv =====
// jls_ram: single-write, single-read grid memory with registered read data.
// Depends on nothing.
module jls_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/jls_dp.sv =====
// jls_dp: datapath of the solver: config registers, both grids, divider,
// stencil accumulator, difference scan and result payload.
// Depends on jls_pkg and jls_ram.
module jls_dp #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  jls_pkg::cmd_t                  cmd,
  output jls_pkg::sts_t                  sts,
  input  logic [jls_pkg::FUNC_W-1:0]     in_func,
  input  logic [jls_pkg::IDX_W-1:0]      in_idx,
  input  logic signed [jls_pkg::IO_W-1:0] in_val,
  input  logic                           cfg_we,
  input  logic [jls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic signed [jls_pkg::IO_W-1:0] res_read,
  output logic [jls_pkg::SWEEP_W-1:0]    res_sweeps,
  output logic [jls_pkg::DIFF_W-1:0]     res_diff,
  output logic                           res_conv
);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int V     = VALUE_BITS;
  localparam int XW    = (AW > jls_pkg::IDX_W) ? AW : jls_pkg::IDX_W;

  // config
  logic [jls_pkg::DIM_W-1:0]  cols_cfg_r, rows_cfg_r;
  logic [jls_pkg::DIFF_W-1:0] tol_r;
  logic [jls_pkg::PAIR_W-1:0] maxp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= jls_pkg::COLS_RST;
      rows_cfg_r <= jls_pkg::ROWS_RST;
      tol_r      <= jls_pkg::TOL_RST;
      maxp_r     <= jls_pkg::PAIRS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jls_pkg::CFG_COLS:  cols_cfg_r <= cfg_wdata[jls_pkg::DIM_W-1:0];
        jls_pkg::CFG_ROWS:  rows_cfg_r <= cfg_wdata[jls_pkg::DIM_W-1:0];
        jls_pkg::CFG_TOL:   tol_r      <= cfg_wdata;
        jls_pkg::CFG_PAIRS: maxp_r     <= cfg_wdata[jls_pkg::PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;

  always_comb begin
    if (cols_cfg_r < 7'd3) begin
      cols_eff = CW'(3);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cols_cfg_r);
    end
    if (rows_cfg_r < 7'd3) begin
      rows_eff = RW'(3);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_cfg_r);
    end
  end

  // latched item
  jls_pkg::func_t              func_r;
  logic [jls_pkg::IDX_W-1:0]   idx_r;
  logic signed [V-1:0]         val_r;
  logic [XW-1:0]               idx_x;
  logic [AW-1:0]               idx_addr;
  logic                        in_range;

  assign idx_x    = XW'(idx_r);
  assign idx_addr = idx_x[AW-1:0];
  assign in_range = 32'(idx_r) < 32'(CELLS);

  // restoring divider: row = idx / cols, col = idx % cols
  logic [jls_pkg::IDX_W-1:0]     dvd_r, quo_r;
  logic [CW-1:0]                 rem_r;
  logic [jls_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [CW:0]                   rem_sh;
  logic                          rem_ge;
  logic                          edge_cell;

  assign rem_sh = {rem_r, dvd_r[jls_pkg::IDX_W-1]};
  assign rem_ge = rem_sh >= {1'b0, cols_eff};
  assign edge_cell = (quo_r == '0) || (32'(quo_r) >= 32'(rows_eff) - 32'd1) ||
                     (rem_r == '0) || (rem_r == cols_eff - CW'(1));

  // scan over interior cells
  logic [AW-1:0] k_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [2:0]    nb_r;
  logic          phase_r;
  logic          col_end, last_cell;

  assign col_end   = col_r == cols_eff - CW'(2);
  assign last_cell = col_end && (row_r == rows_eff - RW'(2));

  // memories
  logic [AW-1:0]       raddr, nb_addr, waddr;
  logic [V-1:0]        rd_a, rd_b;
  logic signed [V-1:0] rd_src;
  logic                we_a, we_b;
  logic [V-1:0]        wd_a, wd_b;
  logic signed [V+1:0] acc_r, sum;
  logic [V-1:0]        quarter;
  logic                sw_wr;

  always_comb begin
    case (nb_r[1:0])
      2'd0:    nb_addr = k_r - AW'(cols_eff);
      2'd1:    nb_addr = k_r + AW'(cols_eff);
      2'd2:    nb_addr = k_r - AW'(1);
      default: nb_addr = k_r + AW'(1);
    endcase
  end

  assign raddr   = cmd.sw_step ? nb_addr : (cmd.diff_step ? k_r : idx_addr);
  assign rd_src  = phase_r ? signed'(rd_b) : signed'(rd_a);
  assign sum     = acc_r + (V+2)'(rd_src);
  assign quarter = sum[V+1:2];
  assign sw_wr   = cmd.sw_step && (nb_r == 3'd4);
  assign waddr   = cmd.load_wr ? idx_addr : k_r;
  assign we_a    = (cmd.load_wr && in_range) || (sw_wr && phase_r);
  assign we_b    = (cmd.load_wr && in_range) || (sw_wr && !phase_r);
  assign wd_a    = cmd.load_wr ? val_r : quarter;
  assign wd_b    = cmd.load_wr ? (edge_cell ? val_r : '0) : quarter;

  jls_ram #(.DEPTH(CELLS), .DW(V)) u_grid_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wd_a), .raddr(raddr), .rdata(rd_a)
  );
  jls_ram #(.DEPTH(CELLS), .DW(V)) u_grid_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wd_b), .raddr(raddr), .rdata(rd_b)
  );

  // difference
  logic signed [V:0] d;
  logic [V-1:0]      d_abs, m_r;
  logic [jls_pkg::DIFF_W-1:0] m_sat;
  logic              conv;
  logic [jls_pkg::PAIR_W:0]   pairs_nxt;
  logic [jls_pkg::PAIR_W-1:0] pairs_r;

  assign d         = (V+1)'(signed'(rd_a)) - (V+1)'(signed'(rd_b));
  assign d_abs     = d[V] ? V'(-d) : V'(d);
  assign m_sat     = (64'(m_r) > 64'(jls_pkg::DIFF_SAT)) ? jls_pkg::DIFF_SAT
                                                         : jls_pkg::DIFF_W'(m_r);
  assign conv      = m_sat <= tol_r;
  assign pairs_nxt = (jls_pkg::PAIR_W+1)'(pairs_r) + 1'b1;

  // result state
  logic [jls_pkg::SWEEP_W-1:0] last_sweeps_r;
  logic [jls_pkg::DIFF_W-1:0]  last_diff_r;
  logic                        last_conv_r;
  logic signed [jls_pkg::IO_W-1:0] res_read_r;
  logic [jls_pkg::SWEEP_W-1:0] res_sweeps_r;
  logic [jls_pkg::DIFF_W-1:0]  res_diff_r;
  logic                        res_conv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sweeps_r <= '0;
      last_diff_r   <= '0;
      last_conv_r   <= 1'b0;
    end else if (cmd.check && (conv || pairs_nxt >= (jls_pkg::PAIR_W+1)'(maxp_r))) begin
      last_sweeps_r <= {pairs_nxt[jls_pkg::PAIR_W-1:0], 1'b0};
      last_diff_r   <= m_sat;
      last_conv_r   <= conv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r    <= jls_pkg::func_t'(in_func);
      idx_r     <= in_idx;
      val_r     <= V'(in_val);
      dvd_r     <= in_idx;
      quo_r     <= '0;
      rem_r     <= '0;
      div_cnt_r <= '0;
      pairs_r   <= '0;
      phase_r   <= 1'b0;
    end
    if (cmd.div_step) begin
      dvd_r     <= dvd_r << 1;
      quo_r     <= {quo_r[jls_pkg::IDX_W-2:0], rem_ge};
      rem_r     <= rem_ge ? CW'(rem_sh - {1'b0, cols_eff}) : rem_sh[CW-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.check) begin
      pairs_r <= pairs_nxt[jls_pkg::PAIR_W-1:0];
    end
    if (cmd.phase_flip) begin
      phase_r <= !phase_r;
    end
    if (cmd.sw_step) begin
      if (nb_r == 3'd0) begin
        acc_r <= '0;
      end else begin
        acc_r <= sum;
      end
    end
    // scan restart wins over the per-cell advance
    if (cmd.cap || cmd.scan_init) begin
      k_r   <= AW'(cols_eff) + AW'(1);
      col_r <= CW'(1);
      row_r <= RW'(1);
      nb_r  <= 3'd0;
      m_r   <= '0;
    end else begin
      if (cmd.diff_step && nb_r[0] && (d_abs > m_r)) begin
        m_r <= d_abs;
      end
      if (sw_wr || (cmd.diff_step && nb_r[0])) begin
        nb_r <= 3'd0;
        if (col_end) begin
          col_r <= CW'(1);
          row_r <= row_r + 1'b1;
          k_r   <= k_r + AW'(3);
        end else begin
          col_r <= col_r + 1'b1;
          k_r   <= k_r + AW'(1);
        end
      end else if (cmd.sw_step || cmd.diff_step) begin
        nb_r <= nb_r + 1'b1;
      end
    end
    if (cmd.resp) begin
      res_read_r   <= (func_r == jls_pkg::FUNC_READ && in_range) ?
                      jls_pkg::IO_W'(signed'(rd_a)) : '0;
      res_sweeps_r <= last_sweeps_r;
      res_diff_r   <= last_diff_r;
      res_conv_r   <= last_conv_r;
    end
  end

  assign sts.func      = func_r;
  assign sts.div_last  = div_cnt_r == jls_pkg::DIV_CNT_W'(jls_pkg::IDX_W - 1);
  assign sts.sw_done   = nb_r == 3'd4;
  assign sts.df_done   = nb_r[0];
  assign sts.last_cell = last_cell;
  assign sts.phase     = phase_r;
  assign sts.finish    = conv || (pairs_nxt >= (jls_pkg::PAIR_W+1)'(maxp_r));

  assign res_read   = res_read_r;
  assign res_sweeps = res_sweeps_r;
  assign res_diff   = res_diff_r;
  assign res_conv   = res_conv_r;
endmodule

// ===== src/jls_ctrl.sv =====
// jls_ctrl: sequencing state machine and result valid of the solver.
// Depends on jls_pkg.
module jls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  jls_pkg::sts_t sts,
  output jls_pkg::cmd_t cmd
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_LOAD   = 8'b0000_0100,
    S_RDADDR = 8'b0000_1000,
    S_SWEEP  = 8'b0001_0000,
    S_DIFF   = 8'b0010_0000,
    S_CHECK  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = state_r == S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          case (sts.func)
            jls_pkg::FUNC_LOAD:  state_nxt = S_DIV;
            jls_pkg::FUNC_SOLVE: state_nxt = S_SWEEP;
            jls_pkg::FUNC_READ:  state_nxt = S_RDADDR;
            default:             state_nxt = S_RESP;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RDADDR: begin
        state_nxt = S_RESP;
      end
      S_SWEEP: begin
        cmd.sw_step = 1'b1;
        if (sts.sw_done && sts.last_cell) begin
          cmd.scan_init  = 1'b1;
          cmd.phase_flip = 1'b1;
          if (sts.phase) begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.diff_step = 1'b1;
        if (sts.df_done && sts.last_cell) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.finish) begin
          state_nxt = S_RESP;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SWEEP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.resp      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // func is taken straight from the port during the accept cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ===== src/jls_checker.sv =====
// jls_checker: port-level assertions for jacobi_laplace_solver, bound to it.
// Depends on the top level's ports only.
module jls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_value,
  input logic [16:0] sweep_count,
  input logic [30:0] final_difference,
  input logic        converged
);
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_value) &&
      $stable(sweep_count) && $stable(final_difference) && $stable(converged))
    else $error("stalled result changed");

  a_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !sweep_count[0])
    else $error("odd sweep count");

  a_conv_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (converged || final_difference != 31'd0) |-> sweep_count != 17'd0)
    else $error("solve status without sweeps");
endmodule

bind jacobi_laplace_solver jls_checker u_jls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .read_value      (out_if.read_value),
  .sweep_count     (out_if.sweep_count),
  .final_difference(out_if.final_difference),
  .converged       (out_if.converged)
);
